### sv/hsv_rsc_pkg.sv
// Package: payload types, CORDIC angle table and shared constants.
`default_nettype none
package hsv_rsc_pkg;
	localparam int HueFracBitsDefault = 6;
	localparam int AngBits = 20;
	localparam int CordicSteps = 24;
	localparam int XyBits = 40;
	localparam int ZBits = 31;
	localparam int CfgWidth = 15;
	localparam int CfgIdxBits = 3;

	localparam logic [CfgIdxBits-1:0] REG_HUE_LOW = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_HUE_HIGH = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_SAT_LOW = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_SAT_HIGH = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_VAL_LOW = 3'd4;
	localparam logic [CfgIdxBits-1:0] REG_VAL_HIGH = 3'd5;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       kept;
	} pix_out_t;

	// Data carried alongside the CORDIC through the pipe.
	typedef struct packed {
		pix_in_t    pix;
		logic [7:0] mx;
		logic [7:0] mn;
		logic       special;
		logic [8:0] special_deg;
	} side_t;

	function automatic logic signed [ZBits-1:0] atan_q20(input int i);
		logic signed [ZBits-1:0] t;
		case (i)
			0: t = 31'sd47185920;  1: t = 31'sd27855475;  2: t = 31'sd14718068;
			3: t = 31'sd7471121;   4: t = 31'sd3750058;   5: t = 31'sd1876857;
			6: t = 31'sd938658;    7: t = 31'sd469357;    8: t = 31'sd234682;
			9: t = 31'sd117342;   10: t = 31'sd58671;    11: t = 31'sd29335;
			12: t = 31'sd14668;   13: t = 31'sd7334;     14: t = 31'sd3667;
			15: t = 31'sd1833;    16: t = 31'sd917;      17: t = 31'sd458;
			18: t = 31'sd229;     19: t = 31'sd115;      20: t = 31'sd57;
			21: t = 31'sd29;      22: t = 31'sd14;       23: t = 31'sd7;
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

### sv/hsv_rsc_cordic_stage.sv
// One pipeline stage of CORDIC vectoring: COUNT micro-rotations, registered.
`default_nettype none
module hsv_rsc_cordic_stage import hsv_rsc_pkg::*; #(
	parameter int FIRST = 0,
	parameter int COUNT = 4
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  logic                    advance,
	input  wire  logic                    in_valid,
	input  wire  logic signed [XyBits-1:0] in_x,
	input  wire  logic signed [XyBits-1:0] in_y,
	input  wire  logic signed [ZBits-1:0]  in_z,
	input  wire  side_t                   in_side,
	output logic                          out_valid,
	output logic signed [XyBits-1:0]      out_x,
	output logic signed [XyBits-1:0]      out_y,
	output logic signed [ZBits-1:0]       out_z,
	output side_t                         out_side
);
	logic signed [XyBits-1:0] x_c, y_c, dx, dy;
	logic signed [ZBits-1:0]  z_c;

	// Arithmetic shift right is the floor of division by a power of two.
	always_comb begin
		x_c = in_x;
		y_c = in_y;
		z_c = in_z;
		for (int k = FIRST; k < FIRST + COUNT; k++) begin
			dx = x_c >>> k;
			dy = y_c >>> k;
			if (!y_c[XyBits-1]) begin
				x_c = x_c + dy;
				y_c = y_c - dx;
				z_c = z_c + atan_q20(k);
			end else begin
				x_c = x_c - dy;
				y_c = y_c + dx;
				z_c = z_c - atan_q20(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_x <= x_c;
			out_y <= y_c;
			out_z <= z_c;
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

### sv/hsv_range_selective_color.sv
// Top level: HSV window test with grey fallback, pipelined one pixel per clock while the output is not stalled.
//
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | in_data  (pix_in_t)
//  out     | out_valid/out_stall | out_data (pix_out_t)
//  cfg     | cfg_we              | cfg_idx, cfg_wdata
//
// The pipe has one setup stage, six CORDIC stages of four
// micro-rotations each, one hue/window stage and the output register.
// One pixel enters per clock; the pipe advances whenever the output register
// is empty or being taken, so out_stall freezes every stage together.
// Reset clears valid bits and configuration registers to zero.
`default_nettype none
module hsv_range_selective_color import hsv_rsc_pkg::*; #(
	parameter int HUE_FRAC_BITS = HueFracBitsDefault
) (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  logic                  in_valid,
	output logic                        in_stall,
	input  wire  pix_in_t               in_data,
	output logic                        out_valid,
	input  wire  logic                  out_stall,
	output pix_out_t                    out_data,
	input  wire  logic                  cfg_we,
	input  wire  logic [CfgIdxBits-1:0] cfg_idx,
	input  wire  logic [CfgWidth-1:0]   cfg_wdata
);
	localparam int NStages = 6;
	localparam int PerStage = CordicSteps / NStages;
	// Hue below 360 degrees fits in nine integer bits plus the fraction.
	localparam int HueBits = HUE_FRAC_BITS + 9;

	logic [14:0] hue_low_q, hue_high_q;
	logic [6:0]  sat_low_q, sat_high_q, val_low_q, val_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q <= '0; hue_high_q <= '0;
			sat_low_q <= '0; sat_high_q <= '0;
			val_low_q <= '0; val_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HUE_LOW:  hue_low_q <= cfg_wdata;
				REG_HUE_HIGH: hue_high_q <= cfg_wdata;
				REG_SAT_LOW:  sat_low_q <= cfg_wdata[6:0];
				REG_SAT_HIGH: sat_high_q <= cfg_wdata[6:0];
				REG_VAL_LOW:  val_low_q <= cfg_wdata[6:0];
				REG_VAL_HIGH: val_high_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless a held result is not being taken.
	logic advance;
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;

	// Stage 1: max/min, equal-channel cases, CORDIC start vector.
	logic [7:0] r, g, b, mx_c, mn_c;
	logic signed [XyBits-1:0] x0, y0;
	logic signed [ZBits-1:0]  z0;
	side_t side0;
	always_comb begin
		r = in_data.pixel_red; g = in_data.pixel_green; b = in_data.pixel_blue;
		mx_c = r; mn_c = r;
		if (g > mx_c) mx_c = g;
		if (b > mx_c) mx_c = b;
		if (g < mn_c) mn_c = g;
		if (b < mn_c) mn_c = b;
		side0.pix = in_data;
		side0.mx = mx_c;
		side0.mn = mn_c;
		side0.special = 1'b1;
		if (g == b) side0.special_deg = (r < g) ? 9'd180 : 9'd0;
		else if (r == g) side0.special_deg = (r > b) ? 9'd60 : 9'd240;
		else if (r == b) side0.special_deg = (g > r) ? 9'd120 : 9'd300;
		else begin
			side0.special = 1'b0;
			side0.special_deg = 9'd0;
		end
		x0 = XyBits'(($signed({2'b0, r, 1'b0}) - $signed({3'b0, g})
			- $signed({3'b0, b}))) <<< 16;
		y0 = XyBits'($signed({1'b0, g}) - $signed({1'b0, b})) * XyBits'(113512);
		z0 = '0;
		if (x0[XyBits-1]) begin
			x0 = -x0;
			y0 = -y0;
			z0 = ZBits'(180) <<< AngBits;
		end
	end

	logic v_s1;
	logic signed [XyBits-1:0] x_s1, y_s1;
	logic signed [ZBits-1:0]  z_s1;
	side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (advance) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1 <= x0; y_s1 <= y0; z_s1 <= z0; side_s1 <= side0;
		end
	end

	// CORDIC stages.
	logic                     cv [NStages+1];
	logic signed [XyBits-1:0] cx [NStages+1];
	logic signed [XyBits-1:0] cy [NStages+1];
	logic signed [ZBits-1:0]  cz [NStages+1];
	side_t                    cs [NStages+1];
	assign cv[0] = v_s1; assign cx[0] = x_s1; assign cy[0] = y_s1;
	assign cz[0] = z_s1; assign cs[0] = side_s1;

	for (genvar s = 0; s < NStages; s++) begin : g_cordic
		hsv_rsc_cordic_stage #(.FIRST(s * PerStage), .COUNT(PerStage)) u_stage (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_valid(cv[s]), .in_x(cx[s]), .in_y(cy[s]), .in_z(cz[s]),
			.in_side(cs[s]),
			.out_valid(cv[s+1]), .out_x(cx[s+1]), .out_y(cy[s+1]),
			.out_z(cz[s+1]), .out_side(cs[s+1])
		);
	end

	// Hue stage: wrap, quantize, window compare, luma.
	side_t sd;
	logic signed [ZBits:0] zw;
	logic [HueBits-1:0] hue_c;
	logic        keep_c;
	logic [15:0] s100, v100, sl, sh, vl, vh;
	logic [23:0] luma_sum;
	assign sd = cs[NStages];
	always_comb begin
		zw = {cz[NStages][ZBits-1], cz[NStages]};
		if (zw < 0) zw = zw + ((ZBits+1)'(360) <<< AngBits);
		if (zw >= ((ZBits+1)'(360) <<< AngBits)) zw = zw - ((ZBits+1)'(360) <<< AngBits);
		if (sd.special) hue_c = HueBits'(sd.special_deg) << HUE_FRAC_BITS;
		else hue_c = HueBits'(zw >>> (AngBits - HUE_FRAC_BITS));
		s100 = 16'd100 * 16'(sd.mx - sd.mn);
		v100 = 16'd100 * 16'(sd.mx);
		sl = 16'(sat_low_q) * 16'(sd.mx);
		sh = 16'(sat_high_q) * 16'(sd.mx);
		vl = 16'(val_low_q) * 16'd255;
		vh = 16'(val_high_q) * 16'd255;
		keep_c = (sd.mx != 8'd0) && hue_low_q <= hue_c && hue_c <= hue_high_q
			&& sl <= s100 && s100 <= sh && vl <= v100 && v100 <= vh;
		luma_sum = 24'd13933 * 24'(sd.pix.pixel_red) + 24'd46871 * 24'(sd.pix.pixel_green)
			+ 24'd4732 * 24'(sd.pix.pixel_blue);
	end

	logic v_s8, keep_s8;
	pix_in_t pix_s8;
	logic [7:0] luma_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (advance) v_s8 <= cv[NStages];
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			keep_s8 <= keep_c; pix_s8 <= sd.pix; luma_s8 <= luma_sum[23:16];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (advance) out_valid <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.kept <= keep_s8;
			out_data.out_red <= keep_s8 ? pix_s8.pixel_red : luma_s8;
			out_data.out_green <= keep_s8 ? pix_s8.pixel_green : luma_s8;
			out_data.out_blue <= keep_s8 ? pix_s8.pixel_blue : luma_s8;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.kept |-> out_data.out_red == out_data.out_green
		&& out_data.out_green == out_data.out_blue)
		else $error("grey pixel channels differ");
endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench for hsv_range_selective_color: table-driven and random pixels checked against a model.
`default_nettype none
module testbench import hsv_rsc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Index past the register list: the block must drop the write.
	localparam logic [CfgIdxBits-1:0] REG_UNMAPPED = 3'd6;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pix_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	pix_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CfgIdxBits-1:0] cfg_idx = '0;
	logic [CfgWidth-1:0] cfg_wdata = '0;

	// Local copy of the window registers.
	int unsigned win_hue_lo, win_hue_hi, win_sat_lo, win_sat_hi, win_val_lo, win_val_hi;

	pix_out_t pending_pix[$];
	int mismatches = 0;
	logic calm = 1'b0;        // no gaps on either side while set
	logic squeeze_go = 1'b0;  // kicks off the long receiver hold-off
	logic squeeze_on = 1'b0;

	// Directed stimulus: typed expectations hold only under the reset windows.
	typedef struct {
		logic [7:0] r, g, b;
		bit         typed;
		pix_out_t   want;
	} pix_row_t;

	pix_row_t dir_rows[] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{8'd54,  8'd54,  8'd54,  1'b0}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{8'd182, 8'd182, 8'd182, 1'b0}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{8'd18,  8'd18,  8'd18,  1'b0}},
		'{8'd1,   8'd1,   8'd1,   1'b0, '0},
		'{8'd10,  8'd200, 8'd200, 1'b0, '0},
		'{8'd200, 8'd200, 8'd10,  1'b0, '0},
		'{8'd10,  8'd10,  8'd200, 1'b0, '0},
		'{8'd30,  8'd220, 8'd30,  1'b0, '0},
		'{8'd220, 8'd30,  8'd220, 1'b0, '0},
		'{8'd255, 8'd254, 8'd0,   1'b0, '0},
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},
		'{8'd0,   8'd1,   8'd255, 1'b0, '0},
		'{8'd170, 8'd85,  8'd0,   1'b0, '0},
		'{8'd1,   8'd0,   8'd0,   1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   1'b0, '0},
		'{8'd128, 8'd64,  8'd200, 1'b0, '0},
		'{8'd85,  8'd170, 8'd255, 1'b0, '0},
		'{8'd254, 8'd127, 8'd1,   1'b0, '0}
	};

	hsv_range_selective_color u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// Hue in 1/64 degree: exact for two equal channels, else 24-step CORDIC
	// vectoring with the angle carried in Q20 degrees.
	function automatic int unsigned hue_units(int unsigned r, int unsigned g, int unsigned b);
		longint x, y, z, dx, dy;
		longint atan_tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
			1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
			3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
		if (g == b)
			return (r < g) ? (180 << 6) : 0;
		if (r == g)
			return (r > b ? 60 : 240) << 6;
		if (r == b)
			return (g > r ? 120 : 300) << 6;
		x = (2 * longint'(r) - longint'(g) - longint'(b)) * 65536;
		y = (longint'(g) - longint'(b)) * 113512;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(180) << 20;
		end
		for (int i = 0; i < 24; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy;
				y -= dx;
				z += atan_tab[i];
			end else begin
				x -= dy;
				y += dx;
				z -= atan_tab[i];
			end
		end
		if (z < 0)
			z += longint'(360) << 20;
		if (z >= (longint'(360) << 20))
			z -= longint'(360) << 20;
		return int'(z >> 14);
	endfunction

	function automatic pix_out_t color_key(pix_in_t p);
		int unsigned r, g, b, mx, mn, h, s100, v100, luma;
		bit hold_color;
		pix_out_t o;
		r = p.pixel_red;
		g = p.pixel_green;
		b = p.pixel_blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		hold_color = 1'b0;
		if (mx != 0) begin
			h = hue_units(r, g, b);
			s100 = 100 * (mx - mn);
			v100 = 100 * mx;
			hold_color = win_hue_lo <= h && h <= win_hue_hi &&
				win_sat_lo * mx <= s100 && s100 <= win_sat_hi * mx &&
				win_val_lo * 255 <= v100 && v100 <= win_val_hi * 255;
		end
		if (hold_color) begin
			o = '{p.pixel_red, p.pixel_green, p.pixel_blue, 1'b1};
		end else begin
			luma = (13933 * r + 46871 * g + 4732 * b) >> 16;
			o = '{luma[7:0], luma[7:0], luma[7:0], 1'b0};
		end
		return o;
	endfunction

	// Random pixel: mostly free, with equal-channel, grey and black cases mixed in.
	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		logic [7:0] a, c;
		a = 8'($urandom);
		c = 8'($urandom);
		case ($urandom_range(0, 9))
			0: p = '{a, c, c};
			1: p = '{a, a, c};
			2: p = '{a, c, a};
			3: p = '{a, a, a};
			4: p = '0;
			default: p = pix_in_t'(24'($urandom));
		endcase
		return p;
	endfunction

	// Write the block and the local copy together; the block must be idle.
	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgWidth-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_HUE_LOW: win_hue_lo = val;
			REG_HUE_HIGH: win_hue_hi = val;
			REG_SAT_LOW: win_sat_lo = val[6:0];
			REG_SAT_HIGH: win_sat_hi = val[6:0];
			REG_VAL_LOW: win_val_lo = val[6:0];
			REG_VAL_HIGH: win_val_hi = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_pix.size() == 0);
		@(posedge clk);
	endtask

	task automatic set_windows(int unsigned hl, hh, sl, sh, vl, vh);
		drain();
		write_reg(REG_HUE_LOW, 15'(hl));
		write_reg(REG_HUE_HIGH, 15'(hh));
		write_reg(REG_SAT_LOW, 15'(sl));
		write_reg(REG_SAT_HIGH, 15'(sh));
		write_reg(REG_VAL_LOW, 15'(vl));
		write_reg(REG_VAL_HIGH, 15'(vh));
	endtask

	// Offer one beat after a random gap; hold it until taken, then queue its result.
	task automatic send_pixel(pix_in_t p);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
		pending_pix.push_back(color_key(p));
	endtask

	// Receiver: check each taken beat, then pick the stall for the next cycle.
	initial begin
		int wait_left;
		pix_out_t want;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_pix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat %h", out_data);
				end else begin
					want = pending_pix.pop_front();
					if (out_data.out_red !== want.out_red ||
						out_data.out_green !== want.out_green ||
						out_data.out_blue !== want.out_blue ||
						out_data.kept !== want.kept) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want r%0d g%0d b%0d k%0b got r%0d g%0d b%0d k%0b",
								want.out_red, want.out_green, want.out_blue, want.kept,
								out_data.out_red, out_data.out_green, out_data.out_blue,
								out_data.kept);
					end
				end
				wait_left = calm ? 0 : $urandom_range(0, 13);
			end
			if (!arst_n || squeeze_on) begin
				out_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Long hold-off so the pipe fills and backs up into the input.
	initial begin
		wait (squeeze_go);
		@(posedge clk);
		squeeze_on <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		squeeze_on <= 1'b0;
	end

	initial begin
		int unsigned hl;
		win_hue_lo = 0; win_hue_hi = 0; win_sat_lo = 0;
		win_sat_hi = 0; win_val_lo = 0; win_val_hi = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset windows pass nothing: typed rows are checked as typed.
		foreach (dir_rows[i]) begin
			send_pixel('{dir_rows[i].r, dir_rows[i].g, dir_rows[i].b});
			if (dir_rows[i].typed)
				pending_pix[$] = dir_rows[i].want;
		end
		in_valid <= 1'b0;

		// Wide open windows: every non-black pixel keeps its color.
		set_windows(0, 23040, 0, 100, 0, 100);
		write_reg(REG_UNMAPPED, 15'h7FFF);
		foreach (dir_rows[i])
			send_pixel('{dir_rows[i].r, dir_rows[i].g, dir_rows[i].b});
		in_valid <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			calm <= (ph == 3);
			case (ph)
				0: set_windows(0, 23040, 0, 100, 0, 100);
				1: set_windows(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
				2: set_windows(0, 15'h7FFF, 0, 127, 0, 127);
				3: set_windows(12000, 4000, 0, 100, 0, 100);
				4: set_windows(0, 23040, 80, 20, 70, 30);
				default: begin
					hl = $urandom_range(0, 23040);
					set_windows(hl, hl + $urandom_range(0, 9000), $urandom_range(0, 50),
						$urandom_range(40, 100), $urandom_range(0, 50), $urandom_range(40, 100));
				end
			endcase
			if (ph == 5)
				squeeze_go <= 1'b1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_pixel(rand_pixel());
			in_valid <= 1'b0;
		end

		wait (pending_pix.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && pending_pix.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
sv/hsv_rsc_pkg.sv
sv/hsv_rsc_cordic_stage.sv
sv/hsv_range_selective_color.sv
verif/testbench.sv
